// File: rtl/core/streaming_substring_search_assert.svh
// Assertion macros used by the checker file
`ifndef STREAMING_SUBSTRING_SEARCH_ASSERT_SVH
`define STREAMING_SUBSTRING_SEARCH_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define SSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the following cycle
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/sss_pkg.sv
`timescale 1ns / 1ps
package sss_pkg;
    localparam int MAX_NEEDLE = 32;
    localparam int FILL_W     = $clog2(MAX_NEEDLE + 1);
    localparam int IDX_W      = $clog2(MAX_NEEDLE);
    localparam int CFG_REGS   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEN = 3'd0;

    // Action codes
    localparam logic ACT_FEED    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic        match_now;
        logic        ignored;
        logic [31:0] total_analyzed;
        logic [15:0] chunk_taken;
    } t_out_item;
endpackage

// File: rtl/core/streaming_substring_search.sv
`timescale 1ns / 1ps
// Streaming substring search: finds the first occurrence of a configured needle
// (1..MAX_NEEDLE bytes) in a byte stream. One byte per clock is accepted while the
// queue has room; each transaction yields one result, which passes only through the
// queue and the output register, as the whole window is compared in parallel against
// a shift line of recent bytes. A two-entry queue decouples input from the compare
// stage; an output register decouples the sink. Configuration writes take effect at
// once, so they should only be made while no transaction is in flight.
module streaming_substring_search import sss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    logic [5:0]              r_len;
    logic [MAX_NEEDLE*8-1:0] r_needle;
    logic [FILL_W-1:0]       w_len;
    logic                    w_fv, w_br;
    t_in_item                w_fi;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= 6'd1;
            r_needle <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LEN) r_len <= i_cfg_data[5:0];
            else if (int'(i_cfg_idx) < CFG_REGS) begin
                for (int k = 0; k < 8; k++)
                    if ((int'(i_cfg_idx) - 1) * 8 + k < MAX_NEEDLE)
                        r_needle[((int'(i_cfg_idx) - 1) * 8 + k) * 8 +: 8] <=
                            i_cfg_data[k*8 +: 8];
            end
        end
    end

    // Effective length
    always_comb begin
        priority if (r_len == 6'd0) w_len = FILL_W'(1);
        else if (32'(r_len) > MAX_NEEDLE) w_len = FILL_W'(MAX_NEEDLE);
        else w_len = FILL_W'(r_len);
    end

    sss_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .o_valid(w_fv), .i_ready(w_br), .o_item(w_fi)
    );

    sss_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_br), .i_item(w_fi),
        .i_needle(r_needle), .i_len(w_len),
        .o_valid, .i_ready, .o_item(o_data)
    );
endmodule

// File: rtl/core/sss_front.sv
`timescale 1ns / 1ps
// Front end: input register slice with queue of accepted transactions
module sss_front import sss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_item o_item
);
    t_in_item   r_q [QDEPTH];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= i_item;
    end
endmodule

// File: rtl/core/sss_back.sv
`timescale 1ns / 1ps
// Back end: history shift line, parallel window compare, counters, output register
module sss_back import sss_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_in_item               i_item,
    input  logic [MAX_NEEDLE*8-1:0] i_needle,
    input  logic [FILL_W-1:0]      i_len,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_out_item              o_item
);
    logic [7:0]        r_hist [MAX_NEEDLE];
    logic [FILL_W-1:0] r_fill;
    logic              r_found;
    logic [31:0]       r_total;
    logic [15:0]       r_chunk;
    logic              r_ov;
    t_out_item         r_out;

    logic              w_take, w_match;
    logic [7:0]        n_hist [MAX_NEEDLE];
    logic [FILL_W-1:0] n_fill;
    logic [31:0]       n_total;
    logic [15:0]       n_chunk;

    assign o_ready = !r_ov || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    // Next history and window compare
    always_comb begin
        n_hist[0] = i_item.data_byte;
        for (int k = 1; k < MAX_NEEDLE; k++) n_hist[k] = r_hist[k-1];
        n_fill  = (r_fill == FILL_W'(MAX_NEEDLE)) ? r_fill : r_fill + 1'b1;
        n_total = (r_total == '1) ? r_total : r_total + 32'd1;
        n_chunk = (r_chunk == '1) ? r_chunk : r_chunk + 16'd1;
        w_match = (n_fill >= i_len);
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            if (FILL_W'(k) < i_len &&
                i_needle[k*8 +: 8] != n_hist[IDX_W'(i_len - FILL_W'(k) - 1'b1)])
                w_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_found <= 1'b0;
            r_total <= '0;
            r_chunk <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_take) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (w_take) begin
                priority if (i_item.action == ACT_RESTART) begin
                    r_fill  <= '0;
                    r_found <= 1'b0;
                    r_total <= '0;
                    r_chunk <= '0;
                    r_out   <= '0;
                end else if (r_found) begin
                    r_out <= '{1'b1, 1'b0, 1'b1, r_total, r_chunk};
                    if (i_item.chunk_end) r_chunk <= '0;
                end else begin
                    r_hist  <= n_hist;
                    r_fill  <= n_fill;
                    r_total <= n_total;
                    r_chunk <= i_item.chunk_end ? 16'd0 : n_chunk;
                    r_found <= w_match;
                    r_out   <= '{w_match, w_match, 1'b0, n_total, n_chunk};
                end
            end
        end
    end
endmodule

// File: rtl/core/sss_checker.sv
`timescale 1ns / 1ps
`include "streaming_substring_search_assert.svh"
// Port-level checks
module sss_checker import sss_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);
    `SSS_ASSERT_IMP(a_match_found, i_clk, i_rst_n, o_valid && o_data.match_now, o_data.found)
    `SSS_ASSERT_IMP(a_ign_found, i_clk, i_rst_n, o_valid && o_data.ignored, o_data.found)
    `SSS_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !(o_data.ignored && o_data.match_now))
    `SSS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule

bind streaming_substring_search sss_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);
